// ===== rtl/vmrb_pkg.sv =====
// ============================================================================
// vmrb_pkg
// Shared types, codes and constants of the variable message ring buffer.
// ============================================================================
package vmrb_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int MAX_MESSAGE  = 64;
    localparam int PTR_W        = 13;
    localparam int CNT_W        = 7;

    localparam logic [31:0] CONFIRM_CODE = 32'h5A5A_5A5A;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        RS_WRITTEN     = 3'd0,
        RS_REFUSED     = 3'd1,
        RS_READ_DATA   = 3'd2,
        RS_EMPTY       = 3'd3,
        RS_BAD_CONFIRM = 3'd4,
        RS_WRAP_RESET  = 3'd5
    } t_status;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP   = 4'd0,
        DP_CLEAR = 4'd1,
        DP_LATCH = 4'd2,
        DP_EVAL  = 4'd3,
        DP_WHDR  = 4'd4,
        DP_WPAY  = 4'd5,
        DP_RHDR  = 4'd6,
        DP_RDEC  = 4'd7,
        DP_RPAY  = 4'd8,
        DP_RFIN  = 4'd9
    } t_dp_op;

    // what follows the evaluation of a request
    typedef enum logic [1:0] {
        NX_DONE = 2'd0,
        NX_WHDR = 2'd1,
        NX_WPAY = 2'd2,
        NX_RHDR = 2'd3
    } t_eval_nx;

    typedef struct packed {
        t_dp_op           op;
        logic [CNT_W-1:0] cnt;
        logic             hdr_cap;   // read data of the previous cycle is a header byte
        logic             pay_emit;  // read data of the previous cycle is a payload byte
        logic             pay_last;
    } t_dp_cmd;

    typedef struct packed {
        t_eval_nx eval_nx;
        logic     rd_pay;     // decoded header has a non-empty payload
        logic     pay_last;   // current payload index is the final one
        logic     clr_last;   // clearing sweep at last address
    } t_dp_sts;

    // byte idx of a record header: confirm, command, size, little endian
    function automatic logic [7:0] hdr_byte(logic [31:0] cmd, logic [CNT_W-1:0] size,
                                            logic [3:0] idx);
        logic [31:0] word;
        case (idx[3:2])
            2'd0:    word = CONFIRM_CODE;
            2'd1:    word = cmd;
            default: word = {{(32-CNT_W){1'b0}}, size};
        endcase
        return word[8*idx[1:0] +: 8];
    endfunction

endpackage

// ===== rtl/vmrb_ram.sv =====
// ============================================================================
// vmrb_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ============================================================================
module vmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vmrb_ctrl.sv =====
// ============================================================================
// vmrb_ctrl
// Sequencer: clears the store, then walks each request through the
// datapath one memory byte per cycle.
// ============================================================================
module vmrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  vmrb_pkg::t_dp_sts i_sts,
    output vmrb_pkg::t_dp_cmd o_cmd
);
    import vmrb_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_EVAL  = 10'b00_0000_0100,
        ST_WHDR  = 10'b00_0000_1000,
        ST_WPAY  = 10'b00_0001_0000,
        ST_RHDR  = 10'b00_0010_0000,
        ST_RCAP  = 10'b00_0100_0000,
        ST_RDEC  = 10'b00_1000_0000,
        ST_RPAY  = 10'b01_0000_0000,
        ST_RFIN  = 10'b10_0000_0000
    } t_state;

    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HEADER_BYTES - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.op       = DP_NOP;
        o_cmd.cnt      = r_cnt;
        o_cmd.hdr_cap  = 1'b0;
        o_cmd.pay_emit = 1'b0;
        o_cmd.pay_last = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.op = DP_EVAL;
                n_cnt    = '0;
                case (i_sts.eval_nx)
                    NX_WHDR: n_state = ST_WHDR;
                    NX_WPAY: n_state = ST_WPAY;
                    NX_RHDR: n_state = ST_RHDR;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_WHDR: begin
                o_cmd.op = DP_WHDR;
                if (r_cnt == HDR_LAST) begin
                    n_state = ST_WPAY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WPAY: begin
                o_cmd.op = DP_WPAY;
                n_state  = ST_IDLE;
            end
            ST_RHDR: begin
                o_cmd.op      = DP_RHDR;
                o_cmd.hdr_cap = (r_cnt != '0);
                if (r_cnt == HDR_LAST) begin
                    n_state = ST_RCAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RCAP: begin
                // last header byte lands this cycle
                o_cmd.hdr_cap = 1'b1;
                n_state       = ST_RDEC;
            end
            ST_RDEC: begin
                o_cmd.op = DP_RDEC;
                n_cnt    = '0;
                n_state  = i_sts.rd_pay ? ST_RPAY : ST_IDLE;
            end
            ST_RPAY: begin
                o_cmd.op       = DP_RPAY;
                o_cmd.pay_emit = (r_cnt != '0);
                if (i_sts.pay_last) begin
                    n_state = ST_RFIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RFIN: begin
                o_cmd.op       = DP_RFIN;
                o_cmd.pay_emit = 1'b1;
                o_cmd.pay_last = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/vmrb_dp.sv =====
// ============================================================================
// vmrb_dp
// Datapath: pointers, room and availability checks, header build and
// decode, byte store and registered result port.
// ============================================================================
module vmrb_dp #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vmrb_pkg::t_dp_cmd             i_cmd,
    output vmrb_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [vmrb_pkg::PTR_W-1:0]    i_cfg_wdata,
    input  logic                          i_kind,
    input  logic                          i_first_beat,
    input  logic                          i_last_beat,
    input  logic [7:0]                    i_data_byte,
    input  logic [31:0]                   i_command_code,
    input  logic [vmrb_pkg::CNT_W-1:0]    i_payload_size,
    input  logic [vmrb_pkg::PTR_W-1:0]    i_read_capacity,
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic                          o_has_data,
    output logic [7:0]                    o_data_out,
    output logic [31:0]                   o_command_out,
    output logic [vmrb_pkg::CNT_W-1:0]    o_size_out,
    output logic                          o_last_result
);
    import vmrb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int SUM_W  = (ADDR_W > PTR_W + 1) ? ADDR_W : PTR_W + 1;
    localparam logic [PTR_W-1:0] STORE_CAP =
        (STORE_BYTES > 8191) ? {PTR_W{1'b1}} : PTR_W'(STORE_BYTES);
    localparam logic [PTR_W-1:0] HDR_P   = PTR_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] HDR_C   = CNT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_MSG = CNT_W'(MAX_MESSAGE);

    // store address of pointer plus offset, modulo the store size
    function automatic logic [ADDR_W-1:0] mem_addr(logic [PTR_W-1:0] ptr,
                                                   logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ptr) + SUM_W'(off);
        return s[ADDR_W-1:0];
    endfunction

    // configuration and pointer state
    logic [PTR_W-1:0]  r_buf_bytes;
    logic [PTR_W-1:0]  r_wp, n_wp, r_rp, n_rp, r_wm, n_wm, r_cursor, n_cursor;
    logic              r_active, n_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // latched request
    logic              r_kind, r_first, r_last;
    logic [7:0]        r_data;
    logic [31:0]       r_cmd;
    logic [CNT_W-1:0]  r_size;
    logic [PTR_W-1:0]  r_cap;

    // write and read working registers
    logic [CNT_W-1:0]  r_wsize, n_wsize;
    logic [95:0]       r_hdr;
    logic [31:0]       r_rd_cmd, n_rd_cmd;
    logic [CNT_W-1:0]  r_rd_size, n_rd_size;

    // result registers
    logic              r_strobe, n_strobe;
    logic [2:0]        r_status, n_status;
    logic              r_has, n_has;
    logic [7:0]        r_dout, n_dout;
    logic [31:0]       r_cout, n_cout;
    logic [CNT_W-1:0]  r_sout, n_sout;
    logic              r_lout, n_lout;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    // checks on the latched request, all signed
    logic signed [PTR_W+1:0] s_wp, s_rp, s_wm, s_av, s_node, s_cap;
    logic [PTR_W-1:0]  avail;
    logic              room_mark, room_lin, room_wrap, w_can;
    logic              rd_mark, rd_lin, rd_wrap_rst;
    logic [PTR_W-1:0]  w_new_wp, w_end;
    logic [31:0]       hdr_size_w;
    logic [CNT_W-1:0]  hdr_size;
    logic              hdr_ok;

    assign avail  = (r_buf_bytes < STORE_CAP) ? r_buf_bytes : STORE_CAP;
    assign s_wp   = $signed({2'b00, r_wp});
    assign s_rp   = $signed({2'b00, r_rp});
    assign s_wm   = $signed({2'b00, r_wm});
    assign s_av   = $signed({2'b00, avail});
    assign s_cap  = $signed({2'b00, r_cap});
    assign s_node = $signed((PTR_W+2)'(r_size) + (PTR_W+2)'(HEADER_BYTES));

    assign room_mark   = (s_rp - s_wp) > s_node;
    assign room_lin    = (s_av - s_wp) > s_node;
    assign room_wrap   = s_rp > s_node;
    assign w_can       = (r_wm != '0) ? room_mark : (room_lin || room_wrap);
    assign w_new_wp    = ((r_wm == '0) && !room_lin) ? '0 : r_wp;
    assign w_end       = r_wp + HDR_P + PTR_W'(r_wsize);

    assign rd_mark     = (s_wm - s_rp) >= s_cap;
    assign rd_lin      = (s_wp - s_rp) >= s_cap;
    assign rd_wrap_rst = s_wp >= s_cap;

    assign hdr_ok     = (r_hdr[31:0] == CONFIRM_CODE);
    assign hdr_size_w = r_hdr[95:64];
    assign hdr_size   = ((|hdr_size_w[31:CNT_W]) || (hdr_size_w[CNT_W-1:0] > MAX_MSG)) ?
                        MAX_MSG : hdr_size_w[CNT_W-1:0];

    // status to the controller
    always_comb begin
        if (r_kind == KIND_READ) begin
            if (r_wm != '0) begin
                o_sts.eval_nx = rd_mark ? NX_RHDR : NX_DONE;
            end else begin
                o_sts.eval_nx = rd_lin ? NX_RHDR : NX_DONE;
            end
        end else if (r_first) begin
            o_sts.eval_nx = w_can ? NX_WHDR : NX_DONE;
        end else begin
            o_sts.eval_nx = r_active ? NX_WPAY : NX_DONE;
        end
        o_sts.rd_pay   = hdr_ok && (hdr_size != '0);
        o_sts.pay_last = (i_cmd.cnt == r_rd_size - 1'b1);
        o_sts.clr_last = &r_clr_addr;
    end

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_wm      = r_wm;
        n_cursor  = r_cursor;
        n_active  = r_active;
        n_wsize   = r_wsize;
        n_rd_cmd  = r_rd_cmd;
        n_rd_size = r_rd_size;
        ram_we    = 1'b0;
        ram_addr  = mem_addr(r_rp, i_cmd.cnt);
        ram_wdata = r_data;
        // plain result unless a data byte overrides
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_has     = 1'b0;
        n_dout    = '0;
        n_cout    = '0;
        n_sout    = '0;
        n_lout    = 1'b1;
        case (i_cmd.op)
            DP_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            DP_EVAL: begin
                if (r_kind == KIND_READ) begin
                    if ((r_wm != '0) && !rd_mark) begin
                        n_strobe = 1'b1;
                        if (rd_wrap_rst) begin
                            n_wm     = '0;
                            n_rp     = '0;
                            n_status = RS_WRAP_RESET;
                        end else begin
                            n_status = RS_EMPTY;
                        end
                    end else if ((r_wm == '0) && !rd_lin) begin
                        n_strobe = 1'b1;
                        n_status = RS_EMPTY;
                    end
                end else if (r_first) begin
                    n_active = 1'b0;
                    if (w_can) begin
                        if ((r_wm == '0) && !room_lin) begin
                            n_wm = r_wp;
                        end
                        n_wp     = w_new_wp;
                        n_cursor = w_new_wp + HDR_P;
                        n_active = 1'b1;
                        n_wsize  = r_size;
                    end else begin
                        n_strobe = 1'b1;
                        n_status = RS_REFUSED;
                    end
                end else if (!r_active) begin
                    n_strobe = 1'b1;
                    n_status = RS_REFUSED;
                end
            end
            DP_WHDR: begin
                ram_we    = 1'b1;
                ram_addr  = mem_addr(r_wp, i_cmd.cnt);
                ram_wdata = hdr_byte(r_cmd, r_wsize, i_cmd.cnt[3:0]);
            end
            DP_WPAY: begin
                ram_addr = mem_addr(r_cursor, '0);
                if (r_cursor != w_end) begin
                    ram_we   = 1'b1;
                    n_cursor = r_cursor + 1'b1;
                end
                if (r_last) begin
                    n_wp     = w_end;
                    n_active = 1'b0;
                end
                n_strobe = 1'b1;
                n_status = RS_WRITTEN;
            end
            DP_RDEC: begin
                n_rd_cmd  = r_hdr[63:32];
                n_rd_size = hdr_size;
                if (!hdr_ok) begin
                    n_strobe = 1'b1;
                    n_status = RS_BAD_CONFIRM;
                end else if (hdr_size == '0) begin
                    n_strobe = 1'b1;
                    n_status = RS_READ_DATA;
                    n_cout   = r_hdr[63:32];
                    n_rp     = r_rp + HDR_P;
                end
            end
            DP_RPAY: begin
                ram_addr = mem_addr(r_rp, HDR_C + i_cmd.cnt);
            end
            DP_RFIN: begin
                n_rp = r_rp + HDR_P + PTR_W'(r_rd_size);
            end
            default: begin
            end
        endcase
        if (i_cmd.pay_emit) begin
            n_strobe = 1'b1;
            n_status = RS_READ_DATA;
            n_has    = 1'b1;
            n_dout   = ram_rdata;
            n_cout   = r_rd_cmd;
            n_sout   = r_rd_size;
            n_lout   = i_cmd.pay_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= PTR_W'(4096);
            r_wp        <= '0;
            r_rp        <= '0;
            r_wm        <= '0;
            r_cursor    <= '0;
            r_active    <= 1'b0;
            r_clr_addr  <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buf_bytes <= i_cfg_wdata;
            end
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_wm     <= n_wm;
            r_cursor <= n_cursor;
            r_active <= n_active;
            r_strobe <= n_strobe;
            if (i_cmd.op == DP_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LATCH) begin
            r_kind  <= i_kind;
            r_first <= i_first_beat;
            r_last  <= i_last_beat;
            r_data  <= i_data_byte;
            r_cmd   <= i_command_code;
            r_size  <= (i_payload_size > MAX_MSG) ? MAX_MSG : i_payload_size;
            r_cap   <= i_read_capacity;
        end
        if (i_cmd.hdr_cap) begin
            r_hdr <= {ram_rdata, r_hdr[95:8]};
        end
        r_wsize   <= n_wsize;
        r_rd_cmd  <= n_rd_cmd;
        r_rd_size <= n_rd_size;
        r_status  <= n_status;
        r_has     <= n_has;
        r_dout    <= n_dout;
        r_cout    <= n_cout;
        r_sout    <= n_sout;
        r_lout    <= n_lout;
    end

    vmrb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_has_data    = r_has;
    assign o_data_out    = r_dout;
    assign o_command_out = r_cout;
    assign o_size_out    = r_sout;
    assign o_last_result = r_lout;

endmodule

// ===== rtl/variable_message_ring_buffer.sv =====
// ============================================================================
// variable_message_ring_buffer
// Ring buffer of variable-length records (12-byte header plus payload) in a
// single-port byte store, fed by write beats and read requests.
// ============================================================================
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  request  | start in, busy out        | i_kind .. i_read_capacity
//  result   | o_strobe out, one cycle   | o_status .. o_last_result
//  config   | i_cfg_we in               | i_cfg_wdata (buffer_bytes)
//
//  Flow: a request is taken when start is high and busy is low. A refused
//  beat and an empty or wrap-reset read end after the evaluation step, and
//  a later write beat after one payload write step; a first write beat
//  first writes the 12 header bytes (through the one store port a byte per
//  cycle); a read that fetches the header ends after the decode on a bad
//  confirm code or empty record, else gives one result per payload byte.
//  Reset: synchronous, active low; afterwards the store is zeroed by a
//  sweep of STORE_BYTES addresses with busy high (config writes still land).
//  Results leave through registers and cannot be held off by the receiver.
//  STORE_BYTES must be a power of two.
//
module variable_message_ring_buffer #(
    parameter int STORE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic        i_first_beat,
    input  logic        i_last_beat,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_command_code,
    input  logic [6:0]  i_payload_size,
    input  logic [12:0] i_read_capacity,
    // configuration
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    // results
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic        o_has_data,
    output logic [7:0]  o_data_out,
    output logic [31:0] o_command_out,
    output logic [6:0]  o_size_out,
    output logic        o_last_result
);
    import vmrb_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: clear sweep, header/payload byte walks
    vmrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // pointers, checks, byte store and result registers
    vmrb_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_first_beat   (i_first_beat),
        .i_last_beat    (i_last_beat),
        .i_data_byte    (i_data_byte),
        .i_command_code (i_command_code),
        .i_payload_size (i_payload_size),
        .i_read_capacity(i_read_capacity),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_has_data     (o_has_data),
        .o_data_out     (o_data_out),
        .o_command_out  (o_command_out),
        .o_size_out     (o_size_out),
        .o_last_result  (o_last_result)
    );

endmodule
